// ----- rtl/fxaa_pkg.sv -----
// ----------------------------------------------------------------------------
// fxaa_pkg
// shared types, register indexes and constants of the edge blend filter
// ----------------------------------------------------------------------------
`default_nettype none
package fxaa_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int ROW_BITS         = 11;
    localparam int HEIGHT_MAX       = 1024;
    localparam int CFG_BITS         = 11;
    localparam int CFG_ADDR_BITS    = 3;

    localparam int WT_R = 218;
    localparam int WT_G = 732;
    localparam int WT_B = 74;

    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_EDGE_FLOOR       = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_EDGE_RATIO_SHIFT = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BLEND_CONTRAST   = 3'd4;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [7:0]  edge_floor;
        logic [2:0]  edge_ratio_shift;
        logic [7:0]  blend_contrast;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        frame_width:      11'd640,
        frame_height:     11'd480,
        edge_floor:       8'd11,
        edge_ratio_shift: 3'd3,
        blend_contrast:   8'd5
    };

    typedef struct packed {
        logic border;
        logic last;
    } t_qflags;

    typedef enum logic {
        FR_IDLE,
        FR_UPDATE
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LUMA,
        BK_EDGE,
        BK_DECIDE,
        BK_DIV,
        BK_SQR,
        BK_BLEND,
        BK_OUT
    } t_back_state;

endpackage
`default_nettype wire

// ----- rtl/fxaa_front.sv -----
// ----------------------------------------------------------------------------
// fxaa_front
// pixel intake: line stores, 3x3 window, raster counters and border marking
// ----------------------------------------------------------------------------
`default_nettype none
module fxaa_front #(
    parameter int MAX_WIDTH    = fxaa_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = fxaa_pkg::CHANNEL_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fxaa_pkg::t_cfg               i_cfg,
    input  wire                          i_valid,
    input  wire [3*CHANNEL_BITS-1:0]     i_pix,
    input  wire                          i_pad,
    output logic                         o_ready,
    output logic                         o_push,
    output logic [27*CHANNEL_BITS+1:0]   o_data,
    input  wire                          i_full
);
    import fxaa_pkg::*;

    localparam int PW  = 3 * CHANNEL_BITS;
    localparam int JW  = $clog2(MAX_WIDTH);
    localparam int WDW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

    logic [PW-1:0] mem_up [MAX_WIDTH];
    logic [PW-1:0] mem_lo [MAX_WIDTH];

    t_front_state r_state, n_state;
    logic [JW-1:0]       r_j;
    logic [ROW_BITS-1:0] r_i;
    logic [PW-1:0]       r_px, r_up_q, r_lo_q;
    logic [9*PW-1:0]     r_win, n_win;

    logic [WDW-1:0]      w_fw, w_wd, w_jx, w_oc;
    logic [ROW_BITS-1:0] w_ht, w_orow;
    logic                w_accept, w_emit, w_last, w_border;
    t_qflags             w_flg;

    assign w_fw = WDW'(i_cfg.frame_width);
    assign w_wd = (w_fw < WDW'(3)) ? WDW'(3) :
                  (w_fw > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : w_fw;
    assign w_ht = (i_cfg.frame_height < ROW_BITS'(3)) ? ROW_BITS'(3) :
                  (i_cfg.frame_height > ROW_BITS'(HEIGHT_MAX)) ? ROW_BITS'(HEIGHT_MAX) :
                  i_cfg.frame_height;
    assign w_jx = WDW'(r_j);

    assign w_accept = i_valid && o_ready;
    assign w_emit   = (r_i >= ROW_BITS'(2)) || ((r_i == ROW_BITS'(1)) && (r_j != '0));
    assign w_last   = (r_i >= w_ht + ROW_BITS'(1));
    assign w_oc     = (r_j == '0) ? (w_wd - WDW'(1)) : (w_jx - WDW'(1));
    assign w_orow   = (r_j == '0) ? (r_i - ROW_BITS'(2)) : (r_i - ROW_BITS'(1));
    assign w_border = (w_orow == '0) || (w_orow >= w_ht - ROW_BITS'(1)) ||
                      (w_oc == '0) || (w_oc >= w_wd - WDW'(1));

    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[(r*3+0)*PW +: PW] = r_win[(r*3+1)*PW +: PW];
            n_win[(r*3+1)*PW +: PW] = r_win[(r*3+2)*PW +: PW];
        end
        n_win[2*PW +: PW] = r_up_q;
        n_win[5*PW +: PW] = r_lo_q;
        n_win[8*PW +: PW] = r_px;
    end

    always_comb begin
        case (r_state)
            FR_IDLE:   n_state = w_accept ? FR_UPDATE : FR_IDLE;
            FR_UPDATE: n_state = FR_IDLE;
            default:   n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        w_flg.border = w_border;
        w_flg.last   = w_last;
        o_ready = (r_state == FR_IDLE) && !i_full;
        o_push  = (r_state == FR_UPDATE) && w_emit;
        o_data  = {n_win, w_flg};
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_up_q <= mem_up[r_j];
            r_lo_q <= mem_lo[r_j];
            r_px   <= i_pad ? '0 : i_pix;
        end
        if (r_state == FR_UPDATE) begin
            mem_up[r_j] <= r_lo_q;
            mem_lo[r_j] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_j     <= '0;
            r_i     <= '0;
            r_win   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FR_UPDATE) begin
                r_win <= n_win;
                if (w_last) begin
                    r_j <= '0;
                    r_i <= '0;
                end else if (w_jx + WDW'(1) >= w_wd) begin
                    r_j <= '0;
                    r_i <= r_i + ROW_BITS'(1);
                end else begin
                    r_j <= r_j + JW'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fxaa_fifo.sv -----
// ----------------------------------------------------------------------------
// fxaa_fifo
// two entry queue of window snapshots between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module fxaa_fifo #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fxaa_back.sv -----
// ----------------------------------------------------------------------------
// fxaa_back
// per pixel filter: luma, edge test, contrast ratio divide, blend, output reg
// ----------------------------------------------------------------------------
`default_nettype none
module fxaa_back #(
    parameter int CHANNEL_BITS = fxaa_pkg::CHANNEL_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  fxaa_pkg::t_cfg             i_cfg,
    input  wire [27*CHANNEL_BITS-1:0]  i_win,
    input  fxaa_pkg::t_qflags          i_flg,
    input  wire                        i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [3*CHANNEL_BITS-1:0]  o_pix,
    output logic                       o_last
);
    import fxaa_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CB;
    localparam int LW = CB + 10;
    localparam int TW = LW + 2;
    localparam int SW = LW + 3;

    t_back_state r_state, n_state;
    logic [3:0]      r_cnt;
    logic [9*PW-1:0] r_win;
    logic            r_last;
    logic [LW-1:0]   r_luma [9];
    logic [LW-1:0]   r_mx, r_mn;
    logic [TW-1:0]   r_gx, r_gy, r_t, r_c4;
    logic [SW-1:0]   r_rem;
    logic [8:0]      r_q;
    logic [16:0]     r_wt;
    logic [PW-1:0]   r_res, r_samp;
    logic            r_ov;
    logic [PW-1:0]   r_od;
    logic            r_ol;

    logic            w_load, w_skip, w_bit;
    logic [3:0]      w_base, w_pick;
    logic [LW-1:0]   w_thr, w_floor, w_mx, w_mn;
    logic [TW-1:0]   w_c4, w_tc;
    logic [7:0]      w_bc;
    logic [SW-1:0]   w_sub;
    logic signed [SW-1:0] w_gx, w_gy, w_ts;
    logic [CB-1:0]   w_orig, w_smp;
    logic signed [CB:0]    w_diff;
    logic signed [CB+18:0] w_prod;
    logic signed [CB+2:0]  w_adj, w_sum;

    function automatic logic [LW-1:0] luma_f(input logic [PW-1:0] p);
        luma_f = LW'(p[0 +: CB]) * LW'(WT_R) + LW'(p[CB +: CB]) * LW'(WT_G) +
                 LW'(p[2*CB +: CB]) * LW'(WT_B);
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic [LW-1:0] l);
        sx = $signed({3'b000, l});
    endfunction

    function automatic logic [TW-1:0] mag(input logic signed [SW-1:0] v);
        mag = v[SW-1] ? TW'(-v) : TW'(v);
    endfunction

    assign w_base = {2'b00, r_cnt[1:0]} + {1'b0, r_cnt[1:0], 1'b0};

    // edge sums from the registered lumas
    always_comb begin
        w_mx = r_luma[4];
        w_mn = r_luma[4];
        for (int k = 0; k < 4; k++) begin
            if (r_luma[1 + 2*k] > w_mx) w_mx = r_luma[1 + 2*k];
            if (r_luma[1 + 2*k] < w_mn) w_mn = r_luma[1 + 2*k];
        end
        w_gx = (sx(r_luma[5]) - sx(r_luma[3])) + (sx(r_luma[2]) - sx(r_luma[0])) +
               (sx(r_luma[8]) - sx(r_luma[6]));
        w_gy = (sx(r_luma[7]) - sx(r_luma[1])) + (sx(r_luma[8]) - sx(r_luma[2])) +
               (sx(r_luma[6]) - sx(r_luma[0]));
        w_ts = sx(r_luma[1]) + sx(r_luma[5]) + sx(r_luma[7]) + sx(r_luma[3]) -
               (sx(r_luma[4]) <<< 2);
    end

    // edge decision and blend setup
    always_comb begin
        w_floor = LW'(i_cfg.edge_floor) << (CB + 2);
        w_thr   = r_mx >> i_cfg.edge_ratio_shift;
        if (w_floor > w_thr) w_thr = w_floor;
        w_skip = (r_mx - r_mn) < w_thr;
        if (r_gy > r_gx) begin
            w_pick = (mag(sx(r_luma[7]) - sx(r_luma[4])) > mag(sx(r_luma[1]) - sx(r_luma[4])))
                     ? 4'd7 : 4'd1;
        end else begin
            w_pick = (mag(sx(r_luma[3]) - sx(r_luma[4])) > mag(sx(r_luma[5]) - sx(r_luma[4])))
                     ? 4'd3 : 4'd5;
        end
        w_bc = (i_cfg.blend_contrast == 8'd0) ? 8'd1 : i_cfg.blend_contrast;
        w_c4 = TW'(w_bc) << (CB + 4);
        w_tc = (r_t > w_c4) ? w_c4 : r_t;
    end

    // restoring divide step and channel blend
    always_comb begin
        w_bit  = r_rem >= {1'b0, r_c4};
        w_sub  = w_bit ? (r_rem - {1'b0, r_c4}) : r_rem;
        w_orig = r_res[r_cnt[1:0]*CB +: CB];
        w_smp  = r_samp[r_cnt[1:0]*CB +: CB];
        w_diff = $signed({1'b0, w_smp}) - $signed({1'b0, w_orig});
        w_prod = w_diff * $signed({1'b0, r_wt});
        w_adj  = (CB+3)'((w_prod + $signed((CB+19)'(32768))) >>> 16);
        w_sum  = $signed({3'b000, w_orig}) + w_adj;
    end

    always_comb begin
        case (r_state)
            BK_IDLE:   n_state = i_empty ? BK_IDLE : (i_flg.border ? BK_OUT : BK_LUMA);
            BK_LUMA:   n_state = (r_cnt == 4'd2) ? BK_EDGE : BK_LUMA;
            BK_EDGE:   n_state = BK_DECIDE;
            BK_DECIDE: n_state = w_skip ? BK_OUT : BK_DIV;
            BK_DIV:    n_state = (r_cnt == 4'd8) ? BK_SQR : BK_DIV;
            BK_SQR:    n_state = BK_BLEND;
            BK_BLEND:  n_state = (r_cnt == 4'd2) ? BK_OUT : BK_BLEND;
            BK_OUT:    n_state = w_load ? BK_IDLE : BK_OUT;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == BK_IDLE) && !i_empty;
        w_load = (r_state == BK_OUT) && (!r_ov || i_ready);
    end

    assign o_valid = r_ov;
    assign o_pix   = r_od;
    assign o_last  = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= 4'd0;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_win  <= i_win;
                r_last <= i_flg.last;
                r_res  <= i_win[4*PW +: PW];
            end
            BK_LUMA: begin
                for (int k = 0; k < 3; k++) begin
                    r_luma[w_base + 4'(k)] <= luma_f(r_win[(w_base + 4'(k))*PW +: PW]);
                end
            end
            BK_EDGE: begin
                r_mx <= w_mx;
                r_mn <= w_mn;
                r_gx <= mag(w_gx);
                r_gy <= mag(w_gy);
                r_t  <= mag(w_ts);
            end
            BK_DECIDE: begin
                r_samp <= r_win[w_pick*PW +: PW];
                r_c4   <= w_c4;
                r_rem  <= {1'b0, w_tc};
                r_q    <= 9'd0;
            end
            BK_DIV: begin
                r_rem <= w_sub << 1;
                r_q   <= {r_q[7:0], w_bit};
            end
            BK_SQR: begin
                r_wt <= {8'd0, r_q} * {8'd0, r_q};
            end
            BK_BLEND: begin
                r_res[r_cnt[1:0]*CB +: CB] <= w_sum[CB-1:0];
            end
            BK_OUT: begin
                if (w_load) begin
                    r_od <= r_res;
                    r_ol <= r_last;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/fxaa_edge_blend_filter_unit.sv -----
// ----------------------------------------------------------------------------
// fxaa_edge_blend_filter_unit
// 3x3 edge blend anti-aliasing filter on a raster rgb pixel stream
// ----------------------------------------------------------------------------
// intake reads the line stores and then updates the window for each pixel;
// border pixels go straight to the output register, flat ones stop after
// the edge decision and blended ones also pass the 9 step contrast divide
// and the one channel per cycle blend; each pixel leaves one line and one
// pixel after it enters; a 2 entry queue lets intake run ahead of filtering
// synchronous active low reset clears counters, window and queue; line stores
// are not cleared and config returns to its default values
`default_nettype none
module fxaa_edge_blend_filter_unit #(
    parameter int MAX_WIDTH    = fxaa_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = fxaa_pkg::CHANNEL_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_cfg_we,
    input  wire [fxaa_pkg::CFG_ADDR_BITS-1:0]        i_cfg_addr,
    input  wire [fxaa_pkg::CFG_BITS-1:0]             i_cfg_wdata,
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    // red_in, green_in, blue_in
    input  wire [((3*CHANNEL_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // is_padding
    input  wire                                      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    // red_out, green_out, blue_out
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                     m_axis_tlast
);
    import fxaa_pkg::*;

    localparam int PW = 3 * CHANNEL_BITS;
    localparam int DW = ((PW + 7) / 8) * 8;
    localparam int QW = 9 * PW + 2;

    t_cfg           r_cfg;
    logic           w_push, w_pop, w_full, w_empty;
    logic [QW-1:0]  w_qin, w_qout;
    logic [PW-1:0]  w_opix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FRAME_WIDTH:      r_cfg.frame_width      <= i_cfg_wdata;
                REG_FRAME_HEIGHT:     r_cfg.frame_height     <= i_cfg_wdata;
                REG_EDGE_FLOOR:       r_cfg.edge_floor       <= i_cfg_wdata[7:0];
                REG_EDGE_RATIO_SHIFT: r_cfg.edge_ratio_shift <= i_cfg_wdata[2:0];
                REG_BLEND_CONTRAST:   r_cfg.blend_contrast   <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    fxaa_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_pix   (s_axis_tdata[PW-1:0]),
        .i_pad   (s_axis_tuser),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_data  (w_qin),
        .i_full  (w_full)
    );

    fxaa_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .i_pop   (w_pop),
        .o_data  (w_qout),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    fxaa_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_win   (w_qout[QW-1:2]),
        .i_flg   (t_qflags'(w_qout[1:0])),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (w_opix),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DW'(w_opix);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");

    a_intake_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken during line store update");

endmodule
`default_nettype wire
